>>> rtl/psv_pkg.sv
// Package for the persistent stack version unit.
// Holds result codes, fixed field widths, parameter defaults and the
// command and status structs shared by the controller and the datapath.
package psv_pkg;

    // Fixed widths of the request and result fields.
    localparam int KIND_W    = 1;
    localparam int VER_W     = 10;
    localparam int VAL_W     = 16;
    localparam int STATUS_W  = 2;

    // Defaults for the top-level parameters.
    localparam int MAX_VERSIONS_DEF = 1024;
    localparam int VALUE_BITS_DEF   = 16;

    // Result codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOVER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Request kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;    // capture a new request
        logic                follow;  // read at the link of the last read node
        logic                write;   // store the new node and advance the free slot
        logic                finish;  // load the result registers
        logic [STATUS_W-1:0] code;    // result code to report on finish
    } psv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ver_bad;    // requested version not yet created
        logic full;       // no free slot left
        logic is_pop;     // captured request is a pop
        logic ver_zero;   // requested version is the empty root
        logic rd_alias;   // node just read is an alias node
        logic link_zero;  // link of the node just read is the empty root
    } psv_stat_t;

endpackage

>>> rtl/persistent_stack_versions_unit.sv
// Top level of the persistent stack version unit.
// Joins psv_ctrl and psv_datapath; depends on psv_pkg.
//
//  Channel   Handshake              Ports
//  request   start && !busy         kind, version, value
//  result    done (one cycle)       status, popped_value, new_version
//
// A push, a pop of the root version, and any request that fails its version or
// full check finish from the check state. Any other pop then walks its chain,
// reading every alias node and the value node it stops at, one read per cycle.
// Reset sets the free slot to 1; a link of 0 stands for the empty root, so no
// clearing pass is needed. The result is shown for one cycle and cannot be
// stalled; a new request may be accepted in that cycle.
module persistent_stack_versions_unit #(
    parameter int MAX_VERSIONS = psv_pkg::MAX_VERSIONS_DEF,
    parameter int VALUE_BITS   = psv_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [psv_pkg::KIND_W-1:0]    kind,
    input  logic [psv_pkg::VER_W-1:0]     version,
    input  logic [psv_pkg::VAL_W-1:0]     value,
    output logic                          done,
    output logic [psv_pkg::STATUS_W-1:0]  status,
    output logic [psv_pkg::VAL_W-1:0]     popped_value,
    output logic [psv_pkg::VER_W-1:0]     new_version
);
    import psv_pkg::*;

    psv_cmd_t  cmd;
    psv_stat_t stat;

    // Sequencing of checks, the link walk and the node write.
    psv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Node memory, free slot counter and result registers.
    psv_datapath #(
        .MAX_VERSIONS (MAX_VERSIONS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .version      (version),
        .value        (value),
        .status       (status),
        .popped_value (popped_value),
        .new_version  (new_version)
    );

endmodule

>>> rtl/psv_ctrl.sv
// Controller state machine of the persistent stack version unit.
// Depends on psv_pkg for the command and status structs and result codes.
module psv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  psv_pkg::psv_stat_t stat,
    output psv_pkg::psv_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import psv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Next state and commands for the datapath.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (stat.ver_bad)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_NOVER;
                end
                else if (stat.full)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_FULL;
                end
                else if (!stat.is_pop)
                begin
                    cmd.write  = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.code   = ST_OK;
                end
                else if (stat.ver_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_EMPTY;
                end
                else
                begin
                    // The read of the named version is under way; walk from it.
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                priority if (!stat.rd_alias)
                begin
                    cmd.write  = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.code   = ST_OK;
                end
                else if (stat.link_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_EMPTY;
                end
                else
                begin
                    cmd.follow = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.finish)
        begin
            state_next = S_IDLE;
        end
        done_next = cmd.finish;
    end

    // State and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

>>> rtl/psv_datapath.sv
// Datapath of the persistent stack version unit: node memory, free slot
// counter, request and result registers. Depends on psv_pkg.
module psv_datapath #(
    parameter int MAX_VERSIONS = psv_pkg::MAX_VERSIONS_DEF,
    parameter int VALUE_BITS   = psv_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psv_pkg::psv_cmd_t             cmd,
    output psv_pkg::psv_stat_t            stat,
    input  logic [psv_pkg::KIND_W-1:0]    kind,
    input  logic [psv_pkg::VER_W-1:0]     version,
    input  logic [psv_pkg::VAL_W-1:0]     value,
    output logic [psv_pkg::STATUS_W-1:0]  status,
    output logic [psv_pkg::VAL_W-1:0]     popped_value,
    output logic [psv_pkg::VER_W-1:0]     new_version
);
    import psv_pkg::*;

    localparam int IDX_W = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
    localparam int NF_W  = IDX_W + 1;
    localparam int CMP_W = (NF_W > VER_W + 1) ? NF_W : VER_W + 1;
    localparam int EXT_W = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;

    typedef struct packed {
        logic                  alias_flag;
        logic [VALUE_BITS-1:0] item;
        logic [IDX_W-1:0]      link;
    } node_t;

    // Node memory; entry 0 is the empty root and its contents are never used.
    node_t mem [MAX_VERSIONS];

    logic                  kind_reg;
    logic [CMP_W-1:0]      ver_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [NF_W-1:0]       next_free_reg;
    logic [NF_W-1:0]       next_free_next;
    node_t                 rd_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [VAL_W-1:0]      popped_reg;
    logic [VER_W-1:0]      new_ver_reg;

    logic [EXT_W-1:0]      val_ext;
    logic [EXT_W-1:0]      item_ext;
    logic [CMP_W-1:0]      slot_ext;
    logic [IDX_W-1:0]      rd_addr;
    node_t                 wr_node;

    // Widened views of the value, the popped item and the free slot.
    assign val_ext  = EXT_W'(value);
    assign item_ext = EXT_W'(rd_reg.item);
    assign slot_ext = CMP_W'(next_free_reg);

    // Checks on the captured request and the last node read.
    assign stat.ver_bad   = (ver_reg >= slot_ext) || (ver_reg >= CMP_W'(MAX_VERSIONS));
    assign stat.full      = (next_free_reg == NF_W'(MAX_VERSIONS));
    assign stat.is_pop    = (kind_reg == KIND_POP);
    assign stat.ver_zero  = (ver_reg == '0);
    assign stat.rd_alias  = rd_reg.alias_flag;
    assign stat.link_zero = (rd_reg.link == '0);

    // Read address: the named version first, then each alias link in turn.
    assign rd_addr = cmd.follow ? rd_reg.link : ver_reg[IDX_W-1:0];

    // New node: a value node for a push, an alias to the top's parent for a pop.
    always_comb
    begin
        if (kind_reg == KIND_POP)
        begin
            wr_node.alias_flag = 1'b1;
            wr_node.item       = '0;
            wr_node.link       = rd_reg.link;
        end
        else
        begin
            wr_node.alias_flag = 1'b0;
            wr_node.item       = val_reg;
            wr_node.link       = ver_reg[IDX_W-1:0];
        end
    end

    assign next_free_next = cmd.write ? next_free_reg + NF_W'(1) : next_free_reg;

    // Node memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[next_free_reg[IDX_W-1:0]] <= wr_node;
        end
        rd_reg <= mem[rd_addr];
    end

    // Free slot counter; slot 0 holds the root from reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= NF_W'(1);
        end
        else
        begin
            next_free_reg <= next_free_next;
        end
    end

    // Request capture and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind[0];
            ver_reg  <= CMP_W'(version);
            val_reg  <= val_ext[VALUE_BITS-1:0];
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.code;
            if (cmd.code == ST_OK)
            begin
                popped_reg  <= (kind_reg == KIND_POP) ? item_ext[VAL_W-1:0] : '0;
                new_ver_reg <= slot_ext[VER_W-1:0];
            end
            else
            begin
                popped_reg  <= '0;
                new_ver_reg <= '0;
            end
        end
    end

    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign new_version  = new_ver_reg;

endmodule

>>> rtl/psv_checker.sv
// Port-level checks for the persistent stack version unit.
// Depends on psv_pkg; bound to persistent_stack_versions_unit below.
module psv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [psv_pkg::STATUS_W-1:0]  status,
    input logic [psv_pkg::VAL_W-1:0]     popped_value,
    input logic [psv_pkg::VER_W-1:0]     new_version
);
    import psv_pkg::*;

    // An accepted request keeps the unit busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the unit busy");

    // A result only follows a busy cycle, and the unit is free while showing it.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without preceding work");

    // Each request gives one result strobe, never two in a row.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // A failed request reports zero value and zero version.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((popped_value == '0) && (new_version == '0)))
        else $error("failed request reported a value or version");

endmodule

bind persistent_stack_versions_unit psv_checker u_psv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .popped_value (popped_value),
    .new_version  (new_version)
);

>>> sim/persistent_stack_versions_unit_test.sv
// Self-checking testbench for persistent_stack_versions_unit: random pushes and pops
// on a versioned stack, with every result checked against a local model of the node table.
// Depends on psv_pkg and the unit's RTL; needs no other files.
`timescale 1ns / 100ps

module persistent_stack_versions_unit_test;

    import psv_pkg::*;

    localparam int DEPTH       = MAX_VERSIONS_DEF;
    localparam int LINK_NONE   = DEPTH;
    localparam int N_RANDOM    = 1830;
    localparam int DRAIN_CYCLES = DEPTH + 80;

    // One request as the sender presents it.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [VER_W-1:0]  version;
        logic [VAL_W-1:0]  value;
        bit                hold;    // wait for every outstanding result first
    } stack_req_t;

    // One result as the unit should report it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    popped;
        logic [VER_W-1:0]    new_ver;
    } stack_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   kind = '0;
    logic [VER_W-1:0]    version = '0;
    logic [VAL_W-1:0]    value = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    popped_value;
    logic [VER_W-1:0]    new_version;

    // Model of the node table.
    bit               node_alias [DEPTH];
    logic [VAL_W-1:0] node_val [DEPTH];
    int               node_link [DEPTH];
    int               free_slot;

    stack_req_t    pending_reqs[$];
    stack_result_t expected_results[$];

    int n_errors = 0;
    int n_checked = 0;
    int n_push_ok = 0;
    int n_pop_ok = 0;
    int n_empty = 0;
    int n_full = 0;
    int n_nover = 0;
    int n_drains = 0;
    int longest_walk = 0;
    int burst_left = 0;
    int gap_left = 0;

    persistent_stack_versions_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .version      (version),
        .value        (value),
        .done         (done),
        .status       (status),
        .popped_value (popped_value),
        .new_version  (new_version)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one request to the model and returns the result it must give.
    function automatic stack_result_t apply_request(logic [KIND_W-1:0] k,
                                                    logic [VER_W-1:0] ver,
                                                    logic [VAL_W-1:0] val);
        stack_result_t r;
        int            idx;
        int            steps;
        r = '{status: ST_OK, popped: '0, new_ver: '0};
        if (int'(ver) >= free_slot) begin
            r.status = ST_NOVER;
            n_nover++;
            return r;
        end
        if (free_slot >= DEPTH) begin
            r.status = ST_FULL;
            n_full++;
            return r;
        end
        if (k == KIND_PUSH) begin
            node_alias[free_slot] = 1'b0;
            node_val[free_slot] = val;
            node_link[free_slot] = int'(ver);
            r.new_ver = free_slot[VER_W-1:0];
            free_slot++;
            n_push_ok++;
            return r;
        end
        // A pop walks alias nodes until it meets a value node or runs off the root.
        idx = int'(ver);
        steps = 0;
        while (idx < DEPTH && node_alias[idx] && steps <= DEPTH) begin
            idx = node_link[idx];
            steps++;
        end
        if (steps > longest_walk)
            longest_walk = steps;
        if (idx >= DEPTH) begin
            r.status = ST_EMPTY;
            n_empty++;
            return r;
        end
        node_alias[free_slot] = 1'b1;
        node_val[free_slot] = '0;
        node_link[free_slot] = node_link[idx];
        r.popped = node_val[idx];
        r.new_ver = free_slot[VER_W-1:0];
        free_slot++;
        n_pop_ok++;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic queue_req(input logic [KIND_W-1:0] k, input int ver, input int val,
                             input bit hold);
        stack_req_t r;
        r.kind = k;
        r.version = ver[VER_W-1:0];
        r.value = val[VAL_W-1:0];
        r.hold = hold;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Driver: records each accepted request and presents the next one in bursts.
    always @(posedge clk)
    begin : drive_requests
        stack_req_t nxt;
        bit         accepted;
        bit         go;
        if (rst_n) begin
            accepted = start && !busy;
            if (accepted) begin
                expected_results.insert(expected_results.size(),
                                        apply_request(kind, version, value));
                void'(pending_reqs.pop_front());
            end
            if (!(start && !accepted)) begin
                go = 1'b0;
                if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs[0];
                    // A done in this cycle means a result is still being taken.
                    if (nxt.hold && (expected_results.size() != 0 || done))
                        go = 1'b0;
                    else if (gap_left > 0)
                        gap_left--;
                    else
                        go = 1'b1;
                end
                if (go) begin
                    kind <= nxt.kind;
                    version <= nxt.version;
                    value <= nxt.value;
                    start <= 1'b1;
                    if (nxt.hold)
                        n_drains++;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed result must match the oldest expectation.
    always @(posedge clk)
    begin : check_results
        stack_result_t want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result with no request outstanding: status %0d", status));
            end
            else begin
                want = expected_results.pop_front();
                n_checked++;
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (popped_value !== want.popped)
                    flag_mismatch($sformatf("popped_value %h, expected %h",
                                            popped_value, want.popped));
                if (new_version !== want.new_ver)
                    flag_mismatch($sformatf("new_version %0d, expected %0d",
                                            new_version, want.new_ver));
            end
        end
    end

    // Stimulus: directed cases, then random requests generated just ahead of the driver.
    initial
    begin : stimulus
        stack_req_t r;
        int         pick;
        int         top_ver;
        int         lo;
        for (int i = 0; i < DEPTH; i++) begin
            node_alias[i] = 1'b0;
            node_val[i] = '0;
            node_link[i] = 0;
        end
        node_alias[0] = 1'b1;
        node_link[0] = LINK_NONE;
        free_slot = 1;

        // Empty root, unknown versions, value extremes and growing alias chains.
        queue_req(KIND_POP, 0, 0, 1'b0);
        queue_req(KIND_PUSH, 1, 16'h1234, 1'b0);
        queue_req(KIND_PUSH, 0, 16'hFFFF, 1'b0);
        queue_req(KIND_PUSH, 1, 16'h0000, 1'b0);
        queue_req(KIND_POP, 2, 16'hFFFF, 1'b0);
        queue_req(KIND_POP, 3, 0, 1'b0);
        queue_req(KIND_POP, 4, 0, 1'b0);
        queue_req(KIND_PUSH, 4, 16'hA5A5, 1'b0);
        queue_req(KIND_POP, 5, 0, 1'b0);
        queue_req(KIND_POP, 6, 0, 1'b0);
        queue_req(KIND_PUSH, 6, 16'h5A5A, 1'b0);
        queue_req(KIND_POP, 7, 0, 1'b0);
        queue_req(KIND_POP, 8, 0, 1'b0);
        queue_req(KIND_PUSH, 9, 16'h7777, 1'b0);
        queue_req(KIND_POP, 1023, 0, 1'b0);
        queue_req(KIND_PUSH, 10'h2AA, 16'hAAAA, 1'b0);
        queue_req(KIND_POP, 10'h155, 16'h5555, 1'b0);
        queue_req(KIND_POP, 1, 0, 1'b1);
        queue_req(KIND_PUSH, 0, 16'h8000, 1'b0);
        queue_req(KIND_PUSH, 10, 16'h0001, 1'b0);
        queue_req(KIND_POP, 11, 0, 1'b0);
        queue_req(KIND_PUSH, 12, 16'h5555, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Random part: mostly work on recent versions so that stacks and chains grow deep.
        for (int i = 0; i < N_RANDOM; i++) begin
            while (pending_reqs.size() >= 4)
                @(negedge clk);
            top_ver = (free_slot > DEPTH - 1) ? DEPTH - 1 : free_slot - 1;
            pick = $urandom_range(0, 99);
            r.kind = KIND_W'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0)
                r.value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            else
                r.value = VAL_W'($urandom_range(0, 65535));
            if (pick < 4) begin
                lo = (free_slot < DEPTH) ? free_slot : 0;
                r.version = VER_W'($urandom_range(lo, DEPTH - 1));
            end
            else if (pick < 8) begin
                r.version = VER_W'($urandom_range(0, DEPTH - 1));
            end
            else if (pick < 50) begin
                r.version = VER_W'(top_ver);
            end
            else if (pick < 75) begin
                r.version = VER_W'(top_ver - int'($urandom_range(0, (top_ver < 8) ? top_ver : 8)));
            end
            else begin
                r.version = VER_W'($urandom_range(0, top_ver));
            end
            r.hold = (i % 300 == 150);
            pending_reqs.insert(pending_reqs.size(), r);
        end

        // Wait for every result, then give any stray strobe time to show.
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d results: %0d pushes, %0d pops with a value, %0d empty pops,",
                 n_checked, n_push_ok, n_pop_ok, n_empty);
        $display("%0d unknown versions, %0d table-full refusals, longest alias walk %0d,",
                 n_nover, n_full, longest_walk);
        $display("%0d drains.", n_drains);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #80_000_000;
        $display("Timeout: requests or results stopped moving.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
